// ===== rtl/mfs_pkg.sv =====
// Shared types, field widths and codes for the music fade sequencer.
package mfs_pkg;

  localparam int OP_W    = 2;
  localparam int TRACK_W = 16;
  localparam int MS_W    = 16;
  localparam int LEVEL_W = 8;
  localparam int NUM_W   = LEVEL_W + MS_W;

  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_PLAY = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP = 2'd2;

  localparam logic [1:0] MODE_SILENCE  = 2'd0;
  localparam logic [1:0] MODE_PLAYING  = 2'd1;
  localparam logic [1:0] MODE_FADE_IN  = 2'd2;
  localparam logic [1:0] MODE_FADE_OUT = 2'd3;

  typedef struct packed {
    logic               start;
    logic [NUM_W-1:0]   num;
    logic [MS_W-1:0]    den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [LEVEL_W-1:0] quo;
  } div_res_t;

endpackage

// ===== rtl/mfs_if.sv =====
// Request and response channel interfaces of the music fade sequencer.
interface mfs_req_if;
  logic                         valid;
  logic                         ready;
  logic [mfs_pkg::OP_W-1:0]     operation;
  logic [mfs_pkg::TRACK_W-1:0]  track_id;
  logic [mfs_pkg::MS_W-1:0]     fade_out_ms;
  logic [mfs_pkg::MS_W-1:0]     fade_in_ms;
  logic [mfs_pkg::LEVEL_W-1:0]  target_level;
  logic [mfs_pkg::MS_W-1:0]     tick_ms;

  modport source (output valid, operation, track_id, fade_out_ms, fade_in_ms,
                  target_level, tick_ms, input ready);
  modport sink (input valid, operation, track_id, fade_out_ms, fade_in_ms,
                target_level, tick_ms, output ready);
endinterface

interface mfs_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [mfs_pkg::LEVEL_W-1:0]  volume_level;
  logic                         volume_update;
  logic                         start_track;
  logic [mfs_pkg::TRACK_W-1:0]  playing_track;
  logic                         halt_track;
  logic [1:0]                   fsm_state;
  logic                         rejected;

  modport source (output valid, volume_level, volume_update, start_track,
                  playing_track, halt_track, fsm_state, rejected, input ready);
  modport sink (input valid, volume_level, volume_update, start_track,
                playing_track, halt_track, fsm_state, rejected, output ready);
endinterface

// ===== rtl/music_fade_sequencer.sv =====
// Top level of the music fade sequencer: request decoding, state and ramp sequencing.
// The block takes one word at a time. A play or stop request, or a tick outside a fade,
// goes from the accept straight to the done state, which writes its response. A tick
// during a fade computes the ramp volume with one 8x16 multiply and a bit-serial
// divider that retires one quotient bit per cycle, passing through the multiply, load,
// divide and done states in that order; a zero ramp length skips the divider. The
// response sits in an output register, and the next request is taken as soon as the
// current one has written its response there, so a response that is not taken holds
// off the next word.
module music_fade_sequencer (
  input logic      clk,
  input logic      rst,
  mfs_req_if.sink  req,
  mfs_rsp_if.source rsp
);
  import mfs_pkg::*;

  localparam logic [2:0] SEQ_IDLE = 3'd0;
  localparam logic [2:0] SEQ_MUL  = 3'd1;
  localparam logic [2:0] SEQ_LOAD = 3'd2;
  localparam logic [2:0] SEQ_DIV  = 3'd3;
  localparam logic [2:0] SEQ_DONE = 3'd4;

  logic [2:0]         seq;
  logic [OP_W-1:0]    op_r;
  logic [TRACK_W-1:0] trk_r;
  logic [MS_W-1:0]    fo_r;
  logic [MS_W-1:0]    fi_r;
  logic [LEVEL_W-1:0] lvl_r;
  logic [NUM_W-1:0]   num_r;
  logic [LEVEL_W-1:0] quo_r;

  logic [1:0]         mode, mode_next;
  logic [TRACK_W-1:0] current_track, current_track_next;
  logic [TRACK_W-1:0] pending_track, pending_track_next;
  logic [LEVEL_W-1:0] pending_level, pending_level_next;
  logic [MS_W-1:0]    pending_fade_out, pending_fade_out_next;
  logic [MS_W-1:0]    pending_fade_in, pending_fade_in_next;
  logic [LEVEL_W-1:0] ramp_start, ramp_start_next;
  logic [LEVEL_W-1:0] ramp_end, ramp_end_next;
  logic [MS_W-1:0]    ramp_length, ramp_length_next;
  logic [MS_W-1:0]    ramp_elapsed, ramp_elapsed_next;
  logic [LEVEL_W-1:0] present_level, present_level_next;

  logic [LEVEL_W-1:0] o_vol;
  logic               o_upd, o_start, o_halt, o_rej;

  logic               out_valid;
  logic [LEVEL_W-1:0] out_vol;
  logic               out_upd, out_start, out_halt, out_rej;
  logic [TRACK_W-1:0] out_track;
  logic [1:0]         out_mode;

  logic               accept, fading, rising, commit;
  logic [MS_W:0]      elapsed_sum;
  logic [LEVEL_W-1:0] span;
  logic [NUM_W-1:0]   product;
  logic [LEVEL_W-1:0] ramp_val;
  div_req_t           div_req;
  div_res_t           div_res;

  assign req.ready   = (seq == SEQ_IDLE);
  assign accept      = req.valid && req.ready;
  assign fading      = (mode == MODE_FADE_IN) || (mode == MODE_FADE_OUT);
  assign rising      = ramp_end >= ramp_start;
  assign elapsed_sum = {1'b0, ramp_elapsed} + {1'b0, req.tick_ms};
  assign span        = rising ? LEVEL_W'(ramp_end - ramp_start)
                              : LEVEL_W'(ramp_start - ramp_end);
  assign product     = NUM_W'(span * ramp_elapsed)
                       + (rising ? '0 : NUM_W'(ramp_length - MS_W'(1)));
  assign commit      = (seq == SEQ_DONE) && (!out_valid || rsp.ready);

  always_comb begin
    if (ramp_length == '0) begin
      ramp_val = ramp_end;
    end else if (rising) begin
      ramp_val = LEVEL_W'(ramp_start + quo_r);
    end else begin
      ramp_val = LEVEL_W'(ramp_start - quo_r);
    end
  end

  assign div_req.start = (seq == SEQ_LOAD);
  assign div_req.num   = num_r;
  assign div_req.den   = ramp_length;

  mfs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .res (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= SEQ_IDLE;
    end else begin
      unique case (seq)
        SEQ_IDLE: begin
          if (accept) begin
            seq <= (req.operation == OP_TICK && fading) ? SEQ_MUL : SEQ_DONE;
          end
        end
        SEQ_MUL: begin
          seq <= (ramp_length == '0) ? SEQ_DONE : SEQ_LOAD;
        end
        SEQ_LOAD: begin
          seq <= SEQ_DIV;
        end
        SEQ_DIV: begin
          if (div_res.done) begin
            seq <= SEQ_DONE;
          end
        end
        SEQ_DONE: begin
          if (commit) begin
            seq <= SEQ_IDLE;
          end
        end
        default: begin
          seq <= SEQ_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= req.operation;
      trk_r <= req.track_id;
      fo_r  <= req.fade_out_ms;
      fi_r  <= req.fade_in_ms;
      lvl_r <= req.target_level;
    end
    if (seq == SEQ_MUL) begin
      num_r <= product;
    end
    if (div_res.done) begin
      quo_r <= div_res.quo;
    end
  end

  always_comb begin
    mode_next             = mode;
    current_track_next    = current_track;
    pending_track_next    = pending_track;
    pending_level_next    = pending_level;
    pending_fade_out_next = pending_fade_out;
    pending_fade_in_next  = pending_fade_in;
    ramp_start_next       = ramp_start;
    ramp_end_next         = ramp_end;
    ramp_length_next      = ramp_length;
    ramp_elapsed_next     = ramp_elapsed;
    present_level_next    = present_level;
    o_vol   = '0;
    o_upd   = 1'b0;
    o_start = 1'b0;
    o_halt  = 1'b0;
    o_rej   = 1'b0;
    unique case (op_r)
      OP_TICK: begin
        if (fading) begin
          present_level_next = ramp_val;
          o_vol = ramp_val;
          o_upd = 1'b1;
          if (ramp_elapsed == ramp_length) begin
            ramp_start_next   = '0;
            ramp_end_next     = '0;
            ramp_length_next  = '0;
            ramp_elapsed_next = '0;
            if (mode == MODE_FADE_IN) begin
              pending_fade_in_next = '0;
              if (pending_fade_out != '0) begin
                ramp_start_next       = ramp_val;
                ramp_length_next      = pending_fade_out;
                mode_next             = MODE_FADE_OUT;
                pending_fade_out_next = '0;
              end else begin
                mode_next = MODE_PLAYING;
              end
            end else begin
              pending_fade_out_next = '0;
              if (pending_track == '0) begin
                mode_next            = MODE_SILENCE;
                o_halt               = 1'b1;
                current_track_next   = '0;
                pending_fade_in_next = '0;
              end else begin
                o_start            = 1'b1;
                current_track_next = pending_track;
                pending_track_next = '0;
                if (pending_fade_in != '0) begin
                  present_level_next   = '0;
                  o_vol                = '0;
                  ramp_end_next        = pending_level;
                  ramp_length_next     = pending_fade_in;
                  mode_next            = MODE_FADE_IN;
                  pending_fade_in_next = '0;
                end else begin
                  present_level_next = pending_level;
                  o_vol              = pending_level;
                  mode_next          = MODE_PLAYING;
                end
              end
            end
          end
        end
      end
      OP_PLAY: begin
        if (trk_r == '0) begin
          o_rej = 1'b1;
        end else if (trk_r != current_track) begin
          pending_track_next = trk_r;
          pending_level_next = lvl_r;
          if (mode == MODE_SILENCE || (mode == MODE_PLAYING && fo_r == '0)) begin
            if (mode == MODE_PLAYING && fi_r != '0) begin
              pending_fade_in_next  = fi_r;
              pending_fade_out_next = '0;
            end
            o_upd              = 1'b1;
            o_start            = 1'b1;
            current_track_next = trk_r;
            pending_track_next = '0;
            if (fi_r == '0) begin
              present_level_next = lvl_r;
              o_vol              = lvl_r;
              mode_next          = MODE_PLAYING;
            end else begin
              present_level_next = '0;
              o_vol              = '0;
              ramp_start_next    = '0;
              ramp_end_next      = lvl_r;
              ramp_length_next   = fi_r;
              ramp_elapsed_next  = '0;
              mode_next          = MODE_FADE_IN;
            end
          end else if (mode == MODE_PLAYING) begin
            pending_fade_in_next  = fi_r;
            pending_fade_out_next = fo_r;
            ramp_start_next       = present_level;
            ramp_end_next         = '0;
            ramp_length_next      = fo_r;
            ramp_elapsed_next     = '0;
            mode_next             = MODE_FADE_OUT;
          end
        end
      end
      OP_STOP: begin
        pending_track_next = '0;
        if (mode != MODE_SILENCE) begin
          ramp_start_next   = '0;
          ramp_end_next     = '0;
          ramp_length_next  = fo_r;
          ramp_elapsed_next = '0;
          if (fo_r != '0) begin
            ramp_start_next = present_level;
            mode_next       = MODE_FADE_OUT;
          end else begin
            mode_next             = MODE_SILENCE;
            o_halt                = 1'b1;
            current_track_next    = '0;
            pending_fade_in_next  = '0;
            pending_fade_out_next = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_SILENCE;
      current_track    <= '0;
      pending_track    <= '0;
      pending_level    <= '0;
      pending_fade_out <= '0;
      pending_fade_in  <= '0;
      ramp_start       <= '0;
      ramp_end         <= '0;
      ramp_length      <= '0;
      ramp_elapsed     <= '0;
      present_level    <= '0;
    end else if (commit) begin
      mode             <= mode_next;
      current_track    <= current_track_next;
      pending_track    <= pending_track_next;
      pending_level    <= pending_level_next;
      pending_fade_out <= pending_fade_out_next;
      pending_fade_in  <= pending_fade_in_next;
      ramp_start       <= ramp_start_next;
      ramp_end         <= ramp_end_next;
      ramp_length      <= ramp_length_next;
      ramp_elapsed     <= ramp_elapsed_next;
      present_level    <= present_level_next;
    end else if (accept && req.operation == OP_TICK && fading) begin
      ramp_elapsed <= (elapsed_sum > {1'b0, ramp_length}) ? ramp_length
                                                          : elapsed_sum[MS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_vol   <= o_vol;
      out_upd   <= o_upd;
      out_start <= o_start;
      out_halt  <= o_halt;
      out_rej   <= o_rej;
      out_track <= current_track_next;
      out_mode  <= mode_next;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.volume_level  = out_vol;
  assign rsp.volume_update = out_upd;
  assign rsp.start_track   = out_start;
  assign rsp.playing_track = out_track;
  assign rsp.halt_track    = out_halt;
  assign rsp.fsm_state     = out_mode;
  assign rsp.rejected      = out_rej;

  a_silent_no_track: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.fsm_state == MODE_SILENCE) |-> (rsp.playing_track == '0))
    else $error("silent response reports a track");

  a_volume_zero_idle: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.volume_update) |-> (rsp.volume_level == '0))
    else $error("volume driven without update flag");

  a_start_halt_excl: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.start_track && rsp.halt_track))
    else $error("start and halt in one response");

  a_div_in_sequence: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (seq == SEQ_DIV))
    else $error("divider finished outside its sequencer step");

endmodule

// ===== rtl/mfs_div.sv =====
// Bit-serial restoring divider producing an 8-bit quotient.
module mfs_div (
  input  logic              clk,
  input  logic              rst,
  input  mfs_pkg::div_req_t req,
  output mfs_pkg::div_res_t res
);
  import mfs_pkg::*;

  logic [MS_W-1:0]    rem;
  logic [MS_W-1:0]    den;
  logic [LEVEL_W-1:0] qs;
  logic [2:0]         cnt;
  logic               busy;
  logic [MS_W:0]      trial;
  logic               fits;

  assign trial = {rem, qs[LEVEL_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 3'd1;
      if (cnt == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.num[NUM_W-1:LEVEL_W];
      qs  <= req.num[LEVEL_W-1:0];
      den <= req.den;
    end else if (busy) begin
      if (fits) begin
        rem <= MS_W'(trial - {1'b0, den});
      end else begin
        rem <= trial[MS_W-1:0];
      end
      qs <= {qs[LEVEL_W-2:0], fits};
    end
  end

  assign res.done = busy && (cnt == 3'd7);
  assign res.quo  = {qs[LEVEL_W-2:0], fits};

endmodule

// ===== verif/tb_music_fade_sequencer.sv =====
// Self-checking testbench for the music fade sequencer with a built-in predictor.
`timescale 1ns / 100ps

module tb_music_fade_sequencer;
  import mfs_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_WORDS = 1550;

  typedef struct packed {
    logic [LEVEL_W-1:0] volume;
    logic               update;
    logic               start;
    logic [TRACK_W-1:0] track;
    logic               halt;
    logic [1:0]         state;
    logic               rej;
  } fade_result_t;

  class fade_score;
    fade_result_t       expected_outcomes[$];
    fade_result_t       res;
    int unsigned        errors = 0;
    int unsigned        checked = 0;
    int unsigned        op_count[4] = '{0, 0, 0, 0};
    int unsigned        starts = 0;
    int unsigned        halts = 0;
    logic [1:0]         mode = MODE_SILENCE;
    logic [TRACK_W-1:0] track = '0;
    logic [TRACK_W-1:0] queued_track = '0;
    logic [LEVEL_W-1:0] queued_level = '0;
    logic [MS_W-1:0]    queued_fade_out = '0;
    logic [MS_W-1:0]    queued_fade_in = '0;
    logic [LEVEL_W-1:0] slope_from = '0;
    logic [LEVEL_W-1:0] slope_to = '0;
    logic [MS_W-1:0]    slope_len = '0;
    logic [MS_W-1:0]    slope_pos = '0;
    logic [LEVEL_W-1:0] level = '0;

    function void set_level(logic [LEVEL_W-1:0] v);
      level = v;
      res.volume = v;
      res.update = 1'b1;
    endfunction

    function void reset_slope();
      slope_from = '0;
      slope_to = '0;
      slope_len = '0;
      slope_pos = '0;
    endfunction

    // Falling ramps round the step up, so the value moves toward the end but never undershoots it.
    function logic [LEVEL_W-1:0] slope_level();
      int unsigned d;
      if (slope_len == 0) return slope_to;
      if (slope_to >= slope_from) begin
        d = slope_to - slope_from;
        return LEVEL_W'(slope_from + (d * slope_pos) / slope_len);
      end
      d = slope_from - slope_to;
      return LEVEL_W'(slope_from - (d * slope_pos + slope_len - 1) / slope_len);
    endfunction

    function void launch(logic [LEVEL_W-1:0] v);
      set_level(v);
      res.start = 1'b1;
      track = queued_track;
      queued_track = '0;
      mode = MODE_PLAYING;
    endfunction

    function void rise(logic [MS_W-1:0] t);
      launch('0);
      slope_from = '0;
      slope_to = queued_level;
      slope_len = t;
      slope_pos = '0;
      mode = MODE_FADE_IN;
    endfunction

    function void fall(logic [MS_W-1:0] t);
      slope_from = level;
      slope_to = '0;
      slope_len = t;
      slope_pos = '0;
      mode = MODE_FADE_OUT;
    endfunction

    function void silence_all();
      mode = MODE_SILENCE;
      res.halt = 1'b1;
      track = '0;
      queued_track = '0;
      queued_fade_in = '0;
      queued_fade_out = '0;
    endfunction

    function void advance(logic [MS_W-1:0] dt);
      int unsigned sum;
      if (mode != MODE_FADE_IN && mode != MODE_FADE_OUT) return;
      sum = slope_pos + dt;
      slope_pos = (sum > slope_len) ? slope_len : MS_W'(sum);
      set_level(slope_level());
      if (slope_pos < slope_len) return;
      if (mode == MODE_FADE_IN) begin
        queued_fade_in = '0;
        reset_slope();
        if (queued_fade_out != 0) begin
          fall(queued_fade_out);
          queued_fade_out = '0;
        end else begin
          mode = MODE_PLAYING;
        end
      end else begin
        queued_fade_out = '0;
        reset_slope();
        if (queued_track == 0) begin
          silence_all();
        end else if (queued_fade_in != 0) begin
          rise(queued_fade_in);
          queued_fade_in = '0;
        end else begin
          launch(queued_level);
        end
      end
    endfunction

    function void take_request(logic [OP_W-1:0] op, logic [TRACK_W-1:0] trk,
                               logic [MS_W-1:0] fo, logic [MS_W-1:0] fi,
                               logic [LEVEL_W-1:0] lvl, logic [MS_W-1:0] dt);
      res = '0;
      op_count[op]++;
      case (op)
        OP_TICK: advance(dt);
        OP_PLAY: begin
          if (trk == 0) begin
            res.rej = 1'b1;
          end else if (trk != track) begin
            queued_track = trk;
            queued_level = lvl;
            if (mode == MODE_SILENCE) begin
              if (fi == 0) launch(queued_level);
              else rise(fi);
            end else if (mode == MODE_PLAYING) begin
              if (fi == 0 && fo == 0) begin
                launch(queued_level);
              end else begin
                queued_fade_in = fi;
                queued_fade_out = fo;
                if (fo != 0) fall(fo);
                else rise(fi);
              end
            end
          end
        end
        OP_STOP: begin
          queued_track = '0;
          if (mode != MODE_SILENCE) begin
            if (fo != 0) begin
              fall(fo);
            end else begin
              silence_all();
              reset_slope();
            end
          end
        end
        default: ;
      endcase
      if (!res.update) res.volume = '0;
      res.track = track;
      res.state = mode;
      if (res.start) starts++;
      if (res.halt) halts++;
      expected_outcomes.push_back(res);
    endfunction

    function void compare_field(string name, logic [TRACK_W-1:0] want,
                                logic [TRACK_W-1:0] seen);
      if (seen !== want) begin
        errors++;
        $display("%0t: %s expected %0h, got %0h", $time, name, want, seen);
      end
    endfunction

    function void check_response(fade_result_t got);
      fade_result_t want;
      if (expected_outcomes.size() == 0) begin
        errors++;
        $display("%0t: response with none expected, expected nothing, got %p", $time, got);
        return;
      end
      want = expected_outcomes.pop_front();
      checked++;
      compare_field("volume_level", want.volume, got.volume);
      compare_field("volume_update", want.update, got.update);
      compare_field("start_track", want.start, got.start);
      compare_field("playing_track", want.track, got.track);
      compare_field("halt_track", want.halt, got.halt);
      compare_field("fsm_state", want.state, got.state);
      compare_field("rejected", want.rej, got.rej);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  bit          steady_run = 1'b0;
  int unsigned cycle_count = 0;
  fade_score   sb = new;

  mfs_req_if req();
  mfs_rsp_if rsp();

  music_fade_sequencer dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_music_fade_sequencer: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        sb.check_response('{rsp.volume_level, rsp.volume_update, rsp.start_track,
                            rsp.playing_track, rsp.halt_track, rsp.fsm_state,
                            rsp.rejected});
      end
      if (req.valid && req.ready) begin
        sb.take_request(req.operation, req.track_id, req.fade_out_ms, req.fade_in_ms,
                        req.target_level, req.tick_ms);
      end
    end
  end

  always @(negedge clk) begin
    rsp.ready <= steady_run || ($urandom_range(99) >= 22);
  end

  function automatic logic [MS_W-1:0] pick_fade();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 30) return '0;
    if (roll < 85) return MS_W'($urandom_range(1, 150));
    return MS_W'($urandom);
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(logic [OP_W-1:0] op, logic [TRACK_W-1:0] trk,
                           logic [MS_W-1:0] fo, logic [MS_W-1:0] fi,
                           logic [LEVEL_W-1:0] lvl, logic [MS_W-1:0] dt);
    while (!steady_run && $urandom_range(99) < 22) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.operation <= op;
    req.track_id <= trk;
    req.fade_out_ms <= fo;
    req.fade_in_ms <= fi;
    req.target_level <= lvl;
    req.tick_ms <= dt;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
  endtask

  initial begin
    int unsigned        roll;
    logic [OP_W-1:0]    op;
    logic [TRACK_W-1:0] trk;
    logic [LEVEL_W-1:0] lvl;
    logic [MS_W-1:0]    dt;

    req.valid = 1'b0;
    req.operation = OP_TICK;
    req.track_id = '0;
    req.fade_out_ms = '0;
    req.fade_in_ms = '0;
    req.target_level = '0;
    req.tick_ms = '0;
    rsp.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_word(OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_word(OP_PLAY, 16'h0000, 16'h0005, 16'h0005, 8'h40, 16'h0000);
    send_word(OP_STOP, 16'h0009, 16'h0000, 16'h0000, 8'h00, 16'h0000);
    send_word(OP_PLAY, 16'h0001, 16'h0000, 16'h0000, 8'hFF, 16'h0000);
    send_word(OP_PLAY, 16'h0001, 16'h000A, 16'h000A, 8'h11, 16'h0000);
    send_word(OP_PLAY, 16'h0002, 16'h0000, 16'h0000, 8'hC0, 16'h0000);
    send_word(OP_PLAY, 16'h0003, 16'h0064, 16'h0032, 8'hA5, 16'h0000);
    send_word(OP_PLAY, 16'h0004, 16'h0007, 16'h0000, 8'h33, 16'h0000);
    send_word(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 8'h00, 16'h001E);
    send_word(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 8'h00, 16'hFFFF);
    send_word(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 8'h00, 16'h000A);
    send_word(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 8'h00, 16'h0028);
    send_word(OP_PLAY, 16'hFFFF, 16'h0000, 16'hFFFF, 8'h80, 16'h0000);
    send_word(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 8'h00, 16'h03E8);
    send_word(OP_STOP, 16'h0000, 16'h0000, 16'h0000, 8'h00, 16'h0000);
    send_word(OP_PLAY, 16'h0005, 16'h0000, 16'h0000, 8'hC8, 16'h0000);
    send_word(OP_PLAY, 16'h0006, 16'hFFFF, 16'h0000, 8'h07, 16'h0000);
    send_word(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 8'h00, 16'hFFFF);
    send_word(OP_STOP, 16'h0000, 16'h0014, 16'h0000, 8'h00, 16'h0000);
    send_word(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 8'h00, 16'h0005);
    send_word(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 8'h00, 16'h0064);
    send_word(OP_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);

    // Mostly small track numbers and short fades so that ramps run to their end.
    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      steady_run = (i >= 500 && i < 800);
      roll = $urandom_range(99);
      if (roll < 3) op = OP_NONE;
      else if (roll < 48) op = OP_TICK;
      else if (roll < 86) op = OP_PLAY;
      else op = OP_STOP;
      roll = $urandom_range(99);
      if (roll < 8) trk = '0;
      else if (roll < 70) trk = TRACK_W'($urandom_range(1, 3));
      else trk = TRACK_W'($urandom);
      lvl = LEVEL_W'($urandom);
      roll = $urandom_range(99);
      if (roll < 5) dt = '0;
      else if (roll < 88) dt = MS_W'($urandom_range(1, 60));
      else dt = MS_W'($urandom);
      send_word(op, trk, pick_fade(), pick_fade(), lvl, dt);
    end
    steady_run = 1'b0;
    req.valid <= 1'b0;

    while (sb.expected_outcomes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d ticks, %0d plays, %0d stops and %0d unknown codes; %0d responses checked.",
             sb.op_count[OP_TICK], sb.op_count[OP_PLAY], sb.op_count[OP_STOP],
             sb.op_count[OP_NONE], sb.checked);
    $display("Tracks started %0d times and halted %0d times.", sb.starts, sb.halts);
    if (sb.errors == 0) begin
      $display("tb_music_fade_sequencer: done, clean");
    end else begin
      $display("tb_music_fade_sequencer: done, errors");
    end
    $finish;
  end

endmodule

// ===== music_fade_sequencer.f =====
rtl/mfs_pkg.sv
rtl/mfs_if.sv
rtl/mfs_div.sv
rtl/music_fade_sequencer.sv
verif/tb_music_fade_sequencer.sv
